// ----- src/cco_pkg.sv -----
// Shared widths, types and pipeline stage map for the capsule overlap test.
package cco_pkg;

  // Coordinate and fixed-point formats
  localparam int COORD_WIDTH     = 16;
  localparam int PARAM_FRAC_BITS = 16;

  localparam int PT_W   = 3 * COORD_WIDTH;
  localparam int RAD_W  = 15;
  localparam int RS_W   = RAD_W + 1;
  localparam int DIST_W = 34;

  // Internal widths
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int Q_W    = PARAM_FRAC_BITS + 1;
  localparam int PQ_W   = DIFF_W + Q_W;
  localparam int DV_W   = DIFF_W + PARAM_FRAC_BITS + 2;
  localparam int MUL_W  = (DOT_W > DV_W) ? DOT_W : DV_W;
  localparam int WIDE_W = 2 * MUL_W;

  localparam logic [Q_W-1:0] ONE_Q = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

  // Latencies of the multiplier and divider units
  localparam int MUL_LAT = 2;
  localparam int DIV_LAT = PARAM_FRAC_BITS + 1;

  // Stage map: register stage at which each result is held
  localparam int ST_DIFF = 1;
  localparam int ST_PROD = ST_DIFF + 1;
  localparam int ST_DOT  = ST_PROD + 1;
  localparam int ST_DEN  = ST_DOT + MUL_LAT + 1;
  localparam int ST_S0   = ST_DEN + DIV_LAT;
  localparam int ST_BS   = ST_S0 + 1;
  localparam int ST_TN   = ST_BS + 1;
  localparam int ST_T    = ST_TN + DIV_LAT;
  localparam int ST_SEL  = ST_T + 1;
  localparam int ST_PRD  = ST_SEL + 1;
  localparam int ST_DV   = ST_PRD + 1;
  localparam int ST_SQ   = ST_DV + MUL_LAT;
  localparam int ST_SUM  = ST_SQ + 1;
  localparam int ST_OUT  = ST_SUM + 1;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PQ_W-1:0]   pq_t;
  typedef logic signed [MUL_W-1:0]  mul_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [Q_W-1:0]           qpar_t;

  // Side data that travels along the pipeline with each item
  typedef struct packed {
    diff_t [2:0]     d1;
    diff_t [2:0]     d2;
    diff_t [2:0]     r;
    logic [RS_W-1:0] rs;
    mul_t            a;
    mul_t            b;
    mul_t            c;
    mul_t            e;
    mul_t            f;
    qpar_t           s0;
    logic            tneg;
    logic            tgt;
  } side_t;

endpackage

// ----- src/capsule_capsule_overlap_test.sv -----
// Capsule-capsule overlap test: top level of the fixed-point pipeline.
// Each beat carries two capsules (segment end points plus radius) and yields
// one beat with the squared closest distance of the two axis segments and a
// hit flag. The pipeline takes one pair per cycle unless the output stalls;
// its path runs through two chained 17-stage dividers (an entry stage, then
// one quotient bit per stage) plus the multiply and sum stages around them.
// The whole pipeline advances when the output register is empty or taken,
// so in_ready follows out_ready while the output is full.
module capsule_capsule_overlap_test (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [cco_pkg::PT_W-1:0]   cap1_start,
  input  logic [cco_pkg::PT_W-1:0]   cap1_end,
  input  logic [cco_pkg::PT_W-1:0]   cap2_start,
  input  logic [cco_pkg::PT_W-1:0]   cap2_end,
  input  logic [cco_pkg::RAD_W-1:0]  cap1_radius,
  input  logic [cco_pkg::RAD_W-1:0]  cap2_radius,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       hit,
  output logic [cco_pkg::DIST_W-1:0] sq_distance
);
  import cco_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int F  = PARAM_FRAC_BITS;

  logic          en;
  logic [ST_OUT:1] vld;
  side_t         side [1:ST_SUM];
  side_t         side_in, sd_dot, sd_bs, sd_tn, sd_t;

  prod_t [2:0]   pa, pb, pe, pc, pf;
  wide_t         ae, bb, bf, ce;
  wide_t         den_c, num1, den1;
  qpar_t         s0_q;
  wide_t         bs;
  wide_t         tn_c, eq_c, diff_c;
  wide_t         num2, den2, num3, den3;
  qpar_t         t2_q, s3_q;
  qpar_t         s_sel, t_sel;
  logic          az, ez;
  pq_t [2:0]     pd1, pd2;
  mul_t [2:0]    dv;
  wide_t [2:0]   sq;
  wide_t         sum;
  logic [2*RS_W-1:0] rs_sq;
  wide_t         thr;

  // Global advance: stall only when the output beat is held
  assign en        = ~vld[ST_OUT] | out_ready;
  assign in_ready  = en;
  assign out_valid = vld[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ST_OUT-1:1], in_valid};
    end
  end

  // Unpack points: direction vectors, start offset and radius sum
  always_comb begin
    side_in = '0;
    for (int k = 0; k < 3; k++) begin
      side_in.d1[k] = diff_t'($signed(cap1_end[k*CW +: CW]))
                    - diff_t'($signed(cap1_start[k*CW +: CW]));
      side_in.d2[k] = diff_t'($signed(cap2_end[k*CW +: CW]))
                    - diff_t'($signed(cap2_start[k*CW +: CW]));
      side_in.r[k]  = diff_t'($signed(cap1_start[k*CW +: CW]))
                    - diff_t'($signed(cap2_start[k*CW +: CW]));
    end
    side_in.rs = RS_W'(cap1_radius) + RS_W'(cap2_radius);
  end

  // Dot products from the per-lane products
  always_comb begin
    sd_dot   = side[ST_PROD];
    sd_dot.a = mul_t'(pa[0]) + mul_t'(pa[1]) + mul_t'(pa[2]);
    sd_dot.b = mul_t'(pb[0]) + mul_t'(pb[1]) + mul_t'(pb[2]);
    sd_dot.e = mul_t'(pe[0]) + mul_t'(pe[1]) + mul_t'(pe[2]);
    sd_dot.c = mul_t'(pc[0]) + mul_t'(pc[1]) + mul_t'(pc[2]);
    sd_dot.f = mul_t'(pf[0]) + mul_t'(pf[1]) + mul_t'(pf[2]);
  end

  always_comb begin
    sd_bs    = side[ST_S0];
    sd_bs.s0 = s0_q;
  end

  // t numerator against e scaled to Q.F
  always_comb begin
    tn_c       = bs + (wide_t'(side[ST_BS].f) <<< F);
    eq_c       = wide_t'(side[ST_BS].e) <<< F;
    diff_c     = tn_c - eq_c;
    sd_tn      = side[ST_BS];
    sd_tn.tneg = tn_c[WIDE_W-1];
    sd_tn.tgt  = !diff_c[WIDE_W-1] && (diff_c != '0);
  end

  // Side data shift line
  always_ff @(posedge clk) begin
    if (en) begin
      side[1] <= side_in;
      for (int k = 2; k <= ST_SUM; k++) begin
        if (k == ST_DOT) begin
          side[k] <= sd_dot;
        end else if (k == ST_BS) begin
          side[k] <= sd_bs;
        end else if (k == ST_TN) begin
          side[k] <= sd_tn;
        end else begin
          side[k] <= side[k-1];
        end
      end
    end
  end

  // Per-lane products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pa[k] <= $signed(side[ST_DIFF].d1[k]) * $signed(side[ST_DIFF].d1[k]);
        pb[k] <= $signed(side[ST_DIFF].d1[k]) * $signed(side[ST_DIFF].d2[k]);
        pe[k] <= $signed(side[ST_DIFF].d2[k]) * $signed(side[ST_DIFF].d2[k]);
        pc[k] <= $signed(side[ST_DIFF].d1[k]) * $signed(side[ST_DIFF].r[k]);
        pf[k] <= $signed(side[ST_DIFF].d2[k]) * $signed(side[ST_DIFF].r[k]);
      end
    end
  end

  // Cross products for the s denominator and numerator
  cco_mul u_mul_ae (.clk(clk), .en(en), .x(side[ST_DOT].a), .y(side[ST_DOT].e), .p(ae));
  cco_mul u_mul_bb (.clk(clk), .en(en), .x(side[ST_DOT].b), .y(side[ST_DOT].b), .p(bb));
  cco_mul u_mul_bf (.clk(clk), .en(en), .x(side[ST_DOT].b), .y(side[ST_DOT].f), .p(bf));
  cco_mul u_mul_ce (.clk(clk), .en(en), .x(side[ST_DOT].c), .y(side[ST_DOT].e), .p(ce));

  // Nonpositive denominator (parallel or degenerate) gives s = 0
  assign den_c = ae - bb;

  always_ff @(posedge clk) begin
    if (en) begin
      den1 <= den_c;
      num1 <= (!den_c[WIDE_W-1] && (den_c != '0)) ? (bf - ce) : '0;
    end
  end

  cco_div u_div_s (.clk(clk), .en(en), .num(num1), .den(den1), .q(s0_q));

  // b * s
  always_ff @(posedge clk) begin
    if (en) begin
      bs <= side[ST_S0].b * $signed({1'b0, s0_q});
    end
  end

  // Divider operands for t and for the recomputed s
  always_ff @(posedge clk) begin
    if (en) begin
      num2 <= tn_c;
      den2 <= eq_c;
      den3 <= wide_t'(side[ST_BS].a);
      if ((side[ST_BS].e == '0) || tn_c[WIDE_W-1]) begin
        num3 <= -wide_t'(side[ST_BS].c);
      end else begin
        num3 <= wide_t'(side[ST_BS].b) - wide_t'(side[ST_BS].c);
      end
    end
  end

  cco_div u_div_t  (.clk(clk), .en(en), .num(num2), .den(den2), .q(t2_q));
  cco_div u_div_s2 (.clk(clk), .en(en), .num(num3), .den(den3), .q(s3_q));

  // Final s and t by case
  assign sd_t = side[ST_T];
  assign az   = (sd_t.a == '0);
  assign ez   = (sd_t.e == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      if (az) begin
        s_sel <= '0;
      end else if (ez || sd_t.tneg || sd_t.tgt) begin
        s_sel <= s3_q;
      end else begin
        s_sel <= sd_t.s0;
      end
      if (ez || sd_t.tneg) begin
        t_sel <= '0;
      end else if (sd_t.tgt) begin
        t_sel <= ONE_Q;
      end else begin
        t_sel <= t2_q;
      end
    end
  end

  // Closest-point difference per lane
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pd1[k] <= $signed(side[ST_SEL].d1[k]) * $signed({1'b0, s_sel});
        pd2[k] <= $signed(side[ST_SEL].d2[k]) * $signed({1'b0, t_sel});
        dv[k]  <= (mul_t'($signed(side[ST_PRD].r[k])) <<< F)
                + mul_t'(pd1[k]) - mul_t'(pd2[k]);
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_sq
    cco_mul u_mul_sq (.clk(clk), .en(en), .x(dv[k]), .y(dv[k]), .p(sq[k]));
  end

  // Squared radius sum in Q.2F
  assign rs_sq = side[ST_SUM].rs * side[ST_SUM].rs;
  assign thr   = wide_t'(rs_sq) <<< (2 * F);

  // Sum of squares and output register
  always_ff @(posedge clk) begin
    if (en) begin
      sum         <= sq[0] + sq[1] + sq[2];
      hit         <= (sum < thr);
      sq_distance <= sum[2*F +: DIST_W];
    end
  end

endmodule

// ----- src/cco_mul.sv -----
// Two-stage signed multiplier built from two half-width partial products.
module cco_mul (
  input  logic          clk,
  input  logic          en,
  input  cco_pkg::mul_t x,
  input  cco_pkg::mul_t y,
  output cco_pkg::wide_t p
);
  import cco_pkg::*;

  localparam int LO_W = MUL_W / 2;
  localparam int HI_W = MUL_W - LO_W;

  logic signed [MUL_W+LO_W:0]   plo;
  logic signed [MUL_W+HI_W-1:0] phi;

  // Partial products, then recombine
  always_ff @(posedge clk) begin
    if (en) begin
      plo <= x * $signed({1'b0, y[LO_W-1:0]});
      phi <= x * $signed(y[MUL_W-1:LO_W]);
      p   <= (wide_t'(phi) <<< LO_W) + wide_t'(plo);
    end
  end

endmodule

// ----- src/cco_div.sv -----
// Pipelined clamped divider: an entry stage, then one quotient bit per stage, result in Q1.F.
module cco_div (
  input  logic           clk,
  input  logic           en,
  input  cco_pkg::wide_t num,
  input  cco_pkg::wide_t den,
  output cco_pkg::qpar_t q
);
  import cco_pkg::*;

  localparam int F     = PARAM_FRAC_BITS;
  localparam int REM_W = WIDE_W + 1;

  logic [REM_W-1:0]  rem [0:F-1];
  logic [WIDE_W-1:0] dv  [0:F-1];
  logic [F-1:0]      qp  [0:F];
  logic [F:0]        zf;
  logic [F:0]        of;
  logic [REM_W-1:0]  sh  [0:F-1];
  logic [F-1:0]      ge;

  // Shift and trial compare for each stage
  always_comb begin
    for (int i = 0; i < F; i++) begin
      sh[i] = {rem[i][REM_W-2:0], 1'b0};
      ge[i] = sh[i] >= {1'b0, dv[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Entry: clamp checks, remainder starts at the numerator
      rem[0] <= {1'b0, $unsigned(num)};
      dv[0]  <= $unsigned(den);
      qp[0]  <= '0;
      zf[0]  <= num[WIDE_W-1] || (num == '0);
      of[0]  <= !num[WIDE_W-1] && (num != '0) && ($unsigned(num) >= $unsigned(den));
      for (int i = 0; i < F; i++) begin
        qp[i+1] <= {qp[i][F-2:0], ge[i]};
        zf[i+1] <= zf[i];
        of[i+1] <= of[i];
      end
      for (int i = 0; i < F - 1; i++) begin
        rem[i+1] <= ge[i] ? (sh[i] - {1'b0, dv[i]}) : sh[i];
        dv[i+1]  <= dv[i];
      end
    end
  end

  assign q = of[F] ? ONE_Q : (zf[F] ? '0 : {1'b0, qp[F]});

endmodule

// ----- src/cco_chk.sv -----
// Port-level checks for the capsule overlap test, bound to the top level.
module cco_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [33:0] sq_distance
);

  // A held output beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(sq_distance))
    else $error("output beat changed while stalled");

  // A stalled output blocks the input side
  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while pipeline stalled");

  // Empty output register never blocks the input side
  a_free_in: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // A hit implies a distance that fits in 32 bits, the range of the squared radius sum
  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> sq_distance[33:32] == 2'b00)
    else $error("hit with distance beyond radius range");

  // Pipeline empties on reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat present after reset");

endmodule

bind capsule_capsule_overlap_test cco_chk u_cco_chk (.*);

// ----- sim/capsule_capsule_overlap_test_tb.sv -----
// Testbench for the capsule-capsule overlap test: directed and random capsule pairs.
module capsule_capsule_overlap_test_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cco_pkg::*;

  localparam int LATENCY  = 49;
  localparam int WDOG_MAX = 4000;
  localparam int FRAC     = PARAM_FRAC_BITS;

  typedef struct {
    logic                hit;
    logic [DIST_W-1:0]   sq_dist;
  } overlap_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PT_W-1:0]  cap1_start = '0, cap1_end = '0, cap2_start = '0, cap2_end = '0;
  logic [RAD_W-1:0] cap1_radius = '0, cap2_radius = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic [DIST_W-1:0] sq_distance;

  overlap_t expected_q[$];
  int unsigned mismatches = 0;
  int unsigned beats_in = 0, beats_out = 0, hits_seen = 0;
  int unsigned wdog = 0;
  bit no_idle = 1'b0;
  bit failed = 1'b0;

  capsule_capsule_overlap_test uut (.*);

  always #10 clk = ~clk;

  // clamp(num/den) to 0..1 in Q1.F, den positive
  function automatic longint clamp_ratio(logic signed [127:0] num, logic signed [127:0] den);
    logic signed [127:0] rem;
    longint q;
    q = 0;
    if (num <= 0) return 0;
    if (num >= den) return longint'(1) << FRAC;
    rem = num;
    for (int i = 0; i < FRAC; i++) begin
      rem = rem <<< 1;
      q = q * 2;
      if (rem >= den) begin
        rem = rem - den;
        q = q + 1;
      end
    end
    return q;
  endfunction

  function automatic longint lane(logic [PT_W-1:0] p, int k);
    logic signed [COORD_WIDTH-1:0] v;
    v = p[k*COORD_WIDTH +: COORD_WIDTH];
    return longint'(v);
  endfunction

  // closest distance of the two axis segments and the overlap decision
  function automatic overlap_t segment_overlap(logic [PT_W-1:0] p1, q1, p2, q2,
                                               logic [RAD_W-1:0] r1, r2);
    longint d1[3], d2[3], rr[3];
    longint a, b, e, c, f, s, t, rs;
    logic signed [127:0] den, eq, tn, sum, dv, thr;
    overlap_t res;
    a = 0; b = 0; e = 0; c = 0; f = 0; s = 0; t = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      d1[i] = lane(q1, i) - lane(p1, i);
      d2[i] = lane(q2, i) - lane(p2, i);
      rr[i] = lane(p1, i) - lane(p2, i);
      a += d1[i] * d1[i];
      b += d1[i] * d2[i];
      e += d2[i] * d2[i];
      c += d1[i] * rr[i];
      f += d2[i] * rr[i];
    end
    if (a == 0 && e == 0) begin
      s = 0; t = 0;
    end else if (a == 0) begin
      t = clamp_ratio(f, e);
    end else if (e == 0) begin
      s = clamp_ratio(-c, a);
    end else begin
      den = 128'(a) * e - 128'(b) * b;
      eq = 128'(e) <<< FRAC;
      s = (den > 0) ? clamp_ratio(128'(b) * f - 128'(c) * e, den) : 0;
      tn = 128'(b) * s + (128'(f) <<< FRAC);
      if (tn < 0) begin
        t = 0;
        s = clamp_ratio(-c, a);
      end else if (tn > eq) begin
        t = longint'(1) << FRAC;
        s = clamp_ratio(b - c, a);
      end else begin
        t = clamp_ratio(tn, eq);
      end
    end
    for (int i = 0; i < 3; i++) begin
      dv = (128'(rr[i]) <<< FRAC) + 128'(d1[i]) * s - 128'(d2[i]) * t;
      sum = sum + dv * dv;
    end
    rs = longint'(r1) + longint'(r2);
    thr = 128'(rs * rs) <<< (2 * FRAC);
    res.hit = (sum < thr);
    res.sq_dist = sum[2*FRAC +: DIST_W];
    return res;
  endfunction

  function automatic logic [PT_W-1:0] pack(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  // random point: half of the time full range, else small or near an extreme
  function automatic logic [PT_W-1:0] rand_point();
    logic [PT_W-1:0] p;
    case ($urandom_range(0, 3))
      0: p = pack($urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100,
                  $urandom_range(0, 200) - 100);
      1: p = pack($urandom_range(0, 1) ? 32767 : -32768, $urandom, $urandom_range(0, 1) ? 32767 : -32768);
      default: p = PT_W'({$urandom, $urandom});
    endcase
    return p;
  endfunction

  // one input beat; valid held until accepted, dropped only while idling
  task automatic send_pair(logic [PT_W-1:0] p1, q1, p2, q2, logic [RAD_W-1:0] r1, r2);
    while (!no_idle && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    cap1_start <= p1; cap1_end <= q1; cap2_start <= p2; cap2_end <= q2;
    cap1_radius <= r1; cap2_radius <= r2;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(segment_overlap(p1, q1, p2, q2, r1, r2));
    beats_in++;
  endtask

  task automatic rand_pair(bit degenerate);
    logic [PT_W-1:0] p1, q1, p2, q2;
    p1 = rand_point(); q1 = rand_point(); p2 = rand_point(); q2 = rand_point();
    if (degenerate) begin
      if ($urandom_range(0, 1)) q1 = p1;
      else q2 = p2;
    end
    send_pair(p1, q1, p2, q2, $urandom_range(0, 32767),
              $urandom_range(0, 3) == 0 ? 15'h7fff : $urandom_range(0, 1000));
  endtask

  // directed: extremes, degenerate segments, parallel, crossing, clamps
  task automatic test_directed();
    send_pair('0, '0, '0, '0, '0, '0);
    send_pair('0, '0, '0, '0, 15'h7fff, 15'h7fff);
    send_pair(pack(-32768, -32768, -32768), pack(-32768, -32768, -32768),
              pack(32767, 32767, 32767), pack(32767, 32767, 32767), 15'h7fff, 15'h7fff);
    send_pair(pack(5, 5, 5), pack(5, 5, 5), pack(0, 0, 0), pack(10, 0, 0), 3, 2);
    send_pair(pack(-100, 0, 0), pack(100, 0, 0), pack(7, 3, 4), pack(7, 3, 4), 1, 4);
    send_pair(pack(0, 0, 0), pack(100, 0, 0), pack(0, 10, 0), pack(100, 10, 0), 5, 5);
    send_pair(pack(0, 0, 0), pack(100, 0, 0), pack(200, 10, 0), pack(300, 10, 0), 5, 5);
    send_pair(pack(0, 0, 0), pack(100, 0, 0), pack(50, -50, 3), pack(50, 50, 3), 1, 1);
    send_pair(pack(0, 0, 0), pack(100, 0, 0), pack(50, -50, 3), pack(50, 50, 3), 2, 2);
    send_pair(pack(0, 0, 0), pack(10, 0, 0), pack(-20, 5, 0), pack(-30, 50, 0), 0, 9);
    send_pair(pack(0, 0, 0), pack(10, 0, 0), pack(40, 5, 0), pack(60, 50, 0), 9, 0);
    send_pair(pack(32767, -32768, 32767), pack(-32768, 32767, -32768),
              pack(-32768, -32768, 32767), pack(32767, 32767, -32768), 0, 0);
    send_pair({16'h8000, 16'h7fff, 16'hffff}, {16'h0001, 16'h8000, 16'h7fff},
              {16'hffff, 16'h0000, 16'h8000}, {16'h7fff, 16'hffff, 16'h0001}, 15'h5555, 15'h2aaa);
    send_pair('1, '1, '0, '1, 15'h7fff, 0);
  endtask

  task automatic test_random();
    for (int i = 0; i < 1800; i++) begin
      no_idle = (i >= 600 && i < 900);
      rand_pair($urandom_range(0, 9) == 0);
    end
    no_idle = 1'b0;
  endtask

  // output side: random stalls, compare with oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 99) >= 12);
      if (out_valid && out_ready) begin
        beats_out++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: hit=%0b dist=%0d", hit, sq_distance);
        end else begin
          overlap_t exp_r;
          exp_r = expected_q.pop_front();
          if (hit) hits_seen++;
          if (hit !== exp_r.hit || sq_distance !== exp_r.sq_dist) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at beat %0d: exp hit=%0b dist=%0d, got hit=%0b dist=%0d",
                       beats_out, exp_r.hit, exp_r.sq_dist, hit, sq_distance);
          end
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog > WDOG_MAX) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    failed = (mismatches != 0) || (expected_q.size() != 0);
    $display("Covered %0d capsule pairs (%0d hits), incl. degenerate and parallel segments.",
             beats_in, hits_seen);
    $display("Result beats checked: %0d, mismatches: %0d", beats_out, mismatches);
    if (!failed) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
src/cco_pkg.sv
src/cco_mul.sv
src/cco_div.sv
src/capsule_capsule_overlap_test.sv
src/cco_chk.sv
sim/capsule_capsule_overlap_test_tb.sv
